/* hdl/dfa_pkg.sv */
// Shared types and constants for the table-driven word recognizer.
// Holds the action, register and sequencer codes plus the command and result records.
// No dependencies; every other file of the block but dfa_checker imports this package.
package dfa_pkg;

	localparam int MAX_STATES  = 32;
	localparam int MAX_SYMBOLS = 8;
	localparam int STATE_W     = $clog2(MAX_STATES);
	localparam int COL_W       = $clog2(MAX_SYMBOLS);
	localparam int ADDR_W      = STATE_W + COL_W;
	localparam int TABLE_DEPTH = MAX_STATES * MAX_SYMBOLS;
	localparam int SYM_W       = 8;
	localparam int ALPHA_W     = 4;
	localparam int NSTATE_W    = 6;
	localparam int CHARS_W     = 64;
	localparam int MASK_W      = 32;
	localparam int CFG_IDX_W   = 2;
	localparam int QDEPTH      = 4;
	localparam int QPTR_W      = $clog2(QDEPTH);

	typedef enum logic [1:0] {
		ACT_WRITE = 2'd0,
		ACT_FEED  = 2'd1,
		ACT_END   = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ALPHA_CHARS = 2'd0,
		CFG_ALPHA_SIZE  = 2'd1,
		CFG_NUM_STATES  = 2'd2,
		CFG_FINAL_MASK  = 2'd3
	} cfg_idx_t;

	typedef enum logic {
		BK_IDLE,
		BK_LOOK
	} back_state_t;

	// A classified request as it travels from the front end to the back end.
	typedef struct packed {
		action_t              action;
		logic [STATE_W-1:0]   row;
		logic [COL_W-1:0]     col;
		logic [STATE_W-1:0]   target;
		logic                 known;
	} cmd_t;

	typedef struct packed {
		logic [STATE_W-1:0] current_state;
		logic               symbol_known;
		logic               word_done;
		logic               accepted;
		logic               bad_word;
	} result_t;

endpackage

/* hdl/dfa_word_recognizer.sv */
// Path: a table write, end-of-word or unknown symbol passes through the queue entry and then the
// result register; a known symbol that walks the table also passes the table read register.
// Throughput: one request a cycle while the queue is not full, except a walking symbol, which holds the
// back end in BK_LOOK because its table read needs the state left by the previous symbol.
// Reset (arst_n low) clears state, error mark, queue and registers; table contents stay unknown.
module dfa_word_recognizer (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write channel. cfg_index selects the register, cfg_data is its value.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	// Request stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // row_state[4:0], column[7:5], target_state[12:8],
	                               // symbol[20:13], zero fill[23:21]
	input  logic [1:0]  s_tuser,   // action[1:0]
	// Result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // current_state[4:0], symbol_known[5], accepted[6],
	                               // bad_word[7]
	output logic        m_tuser    // word_done[0]
);
	import dfa_pkg::*;

	// Configuration registers. The user must issue writes only while the block is idle; the block
	// does not enforce this, and the front and back ends read these directly without any handover.
	logic [CHARS_W-1:0]  alphabet_chars_q;
	logic [ALPHA_W-1:0]  alphabet_size_q;
	logic [NSTATE_W-1:0] num_states_q;
	logic [MASK_W-1:0]   final_mask_q;

	logic    push, pop, full, empty;
	cmd_t    push_cmd, head;
	result_t res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alphabet_chars_q <= '0;
			alphabet_size_q  <= '0;
			num_states_q     <= NSTATE_W'(1);
			final_mask_q     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ALPHA_CHARS: alphabet_chars_q <= cfg_data;
				CFG_ALPHA_SIZE:  alphabet_size_q  <= cfg_data[ALPHA_W-1:0];
				CFG_NUM_STATES:  num_states_q     <= cfg_data[NSTATE_W-1:0];
				CFG_FINAL_MASK:  final_mask_q     <= cfg_data[MASK_W-1:0];
				default: ;
			endcase
		end
	end

	// The front end classifies each request and the symbol match happens here,
	// so the back end only ever sees a resolved column.
	dfa_front u_front (
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.alphabet_chars (alphabet_chars_q),
		.alphabet_size  (alphabet_size_q),
		.queue_full     (full),
		.push           (push),
		.push_cmd       (push_cmd)
	);

	// The queue lets requests keep arriving while the back end waits on a table read
	// or on a stalled result consumer.
	dfa_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full),
		.pop      (pop),
		.empty    (empty),
		.head     (head)
	);

	// The back end holds the table memory, the current state and the error mark, and
	// drives the result register.
	dfa_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.empty      (empty),
		.head       (head),
		.pop        (pop),
		.num_states (num_states_q),
		.final_mask (final_mask_q),
		.res_valid  (m_tvalid),
		.res_ready  (m_tready),
		.res        (res)
	);

	assign m_tdata = {res.bad_word, res.accepted, res.symbol_known, res.current_state};
	assign m_tuser = res.word_done;

endmodule

/* hdl/dfa_front.sv */
// Front end: accepts input requests and matches the symbol against the alphabet.
// Depends on dfa_pkg; feeds dfa_queue.
module dfa_front (
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [23:0]                         s_tdata,
	input  logic [1:0]                          s_tuser,
	input  logic [dfa_pkg::CHARS_W-1:0]         alphabet_chars,
	input  logic [dfa_pkg::ALPHA_W-1:0]         alphabet_size,
	input  logic                                queue_full,
	output logic                                push,
	output dfa_pkg::cmd_t                       push_cmd
);
	import dfa_pkg::*;

	logic [ALPHA_W-1:0] col_count;
	logic [SYM_W-1:0]   sym;
	logic               hit;
	logic [COL_W-1:0]   hit_col;

	assign sym       = s_tdata[20:13];
	assign col_count = (alphabet_size > ALPHA_W'(MAX_SYMBOLS)) ? ALPHA_W'(MAX_SYMBOLS)
	                                                           : alphabet_size;

	// Walk from the top column down so that the lowest matching column wins.
	always_comb begin
		hit     = 1'b0;
		hit_col = '0;
		for (int i = MAX_SYMBOLS - 1; i >= 0; i--) begin
			if ((ALPHA_W'(i) < col_count) && (alphabet_chars[8*i +: 8] == sym)) begin
				hit     = 1'b1;
				hit_col = COL_W'(i);
			end
		end
	end

	always_comb begin
		push_cmd.action = action_t'(s_tuser);
		push_cmd.row    = s_tdata[4:0];
		push_cmd.col    = (action_t'(s_tuser) == ACT_FEED) ? hit_col : s_tdata[7:5];
		push_cmd.target = s_tdata[12:8];
		push_cmd.known  = hit;
	end

	assign s_tready = !queue_full;
	assign push     = s_tvalid && !queue_full;

endmodule

/* hdl/dfa_queue.sv */
// Short request queue that decouples the front end from the back end.
// Depends on dfa_pkg for the command record and the depth.
module dfa_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  dfa_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output dfa_pkg::cmd_t head
);
	import dfa_pkg::*;

	cmd_t              entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full  = (count_q == (QPTR_W+1)'(QDEPTH));
	assign empty = (count_q == '0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* hdl/dfa_back.sv */
// Back end: owns the next-state table and the automaton state, produces results.
// Depends on dfa_pkg; takes requests from dfa_queue.
module dfa_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          empty,
	input  dfa_pkg::cmd_t                 head,
	output logic                          pop,
	input  logic [dfa_pkg::NSTATE_W-1:0]  num_states,
	input  logic [dfa_pkg::MASK_W-1:0]    final_mask,
	output logic                          res_valid,
	input  logic                          res_ready,
	output dfa_pkg::result_t              res
);
	import dfa_pkg::*;

	logic [STATE_W-1:0] table_mem [TABLE_DEPTH];
	logic [STATE_W-1:0] rdata_q;

	back_state_t        bk_q, bk_d;
	logic [STATE_W-1:0] state_now_q, state_d;
	logic               word_err_q, err_d;
	logic               res_valid_q;
	result_t            res_q, res_d;

	logic               slot_free;
	logic               mem_we, mem_re, load;
	logic [NSTATE_W-1:0] state_cnt;
	logic               need_look;

	assign slot_free = !res_valid_q || res_ready;
	assign state_cnt = (num_states > NSTATE_W'(MAX_STATES)) ? NSTATE_W'(MAX_STATES)
	                                                        : num_states;
	assign need_look = (head.action == ACT_FEED) && head.known && !word_err_q;

	always_comb begin
		bk_d = bk_q;
		case (bk_q)
			BK_IDLE: begin
				if (!empty && slot_free && need_look) begin
					bk_d = BK_LOOK;
				end
			end
			BK_LOOK: begin
				if (slot_free) begin
					bk_d = BK_IDLE;
				end
			end
			default: bk_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop     = 1'b0;
		mem_we  = 1'b0;
		mem_re  = 1'b0;
		load    = 1'b0;
		state_d = state_now_q;
		err_d   = word_err_q;
		res_d   = '0;
		case (bk_q)
			BK_IDLE: begin
				if (!empty && slot_free) begin
					pop = 1'b1;
					case (head.action)
						ACT_WRITE: begin
							mem_we = 1'b1;
							load   = 1'b1;
						end
						ACT_FEED: begin
							if (!head.known) begin
								err_d = 1'b1;
								load  = 1'b1;
							end else if (word_err_q) begin
								res_d.symbol_known = 1'b1;
								load               = 1'b1;
							end else begin
								mem_re = 1'b1;
							end
						end
						ACT_END: begin
							res_d.word_done = 1'b1;
							res_d.accepted  = !word_err_q && final_mask[state_now_q];
							state_d         = '0;
							err_d           = 1'b0;
							load            = 1'b1;
						end
						default: load = 1'b1;
					endcase
				end
			end
			BK_LOOK: begin
				if (slot_free) begin
					res_d.symbol_known = 1'b1;
					load               = 1'b1;
					if ({1'b0, rdata_q} >= state_cnt) begin
						err_d = 1'b1;
					end else begin
						state_d = rdata_q;
					end
				end
			end
			default: ;
		endcase
		res_d.current_state = state_d;
		// An end-of-word result reports the mark of the finished word.
		res_d.bad_word = (res_d.word_done) ? word_err_q : err_d;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			table_mem[{head.row, head.col}] <= head.target;
		end
		if (mem_re) begin
			rdata_q <= table_mem[{state_now_q, head.col}];
		end
		if (load) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bk_q        <= BK_IDLE;
			state_now_q <= '0;
			word_err_q  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			bk_q        <= bk_d;
			state_now_q <= state_d;
			word_err_q  <= err_d;
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

/* hdl/dfa_checker.sv */
// Port-level checks for the word recognizer, attached by the bind at the end of this file.
// Depends only on the top level's ports.
module dfa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic        m_tuser
);

	// A stalled result holds its value until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Finishing a word always returns the automaton to the initial state.
	a_end_state: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[4:0] == 5'd0)
		else $error("end-of-word result not in initial state");

	// Acceptance is only reported on a finished word that carries no error mark.
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[6] |-> m_tuser && !m_tdata[7])
		else $error("accepted set outside a clean end-of-word result");

	// A matched symbol never comes with an end-of-word flag.
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[5] |-> !m_tuser)
		else $error("symbol_known set on an end-of-word result");

endmodule

bind dfa_word_recognizer dfa_checker u_checker (.*);

/* verif/tb.sv */
// Self-checking testbench for the table-driven word recognizer dfa_word_recognizer.
// Drives table loads, symbols and word ends over the request stream and checks every result.
// Depends on dfa_pkg for the action and register codes and the result record.
module tb;
	import dfa_pkg::*;

	// Timeout bound for the whole run, with wide margin over the slowest correct run.
	localparam int LIMIT_CYCLES   = 400000;
	localparam int RX_HOLD_CYCLES = 64;
	localparam int RAND_PHASES    = 6;
	localparam int PHASE_ITEMS    = 150;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic        m_tuser;

	dfa_word_recognizer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	// Shadow copy of the recognizer: registers, next-state table and the walk position.
	logic [63:0] sh_chars;
	logic [3:0]  sh_size;
	logic [5:0]  sh_nstates;
	logic [31:0] sh_mask;
	logic [4:0]  sh_next [TABLE_DEPTH];
	bit          sh_loaded [TABLE_DEPTH];
	logic [4:0]  walk_state;
	logic        walk_bad;

	// Expected results in request order, oldest at the front.
	result_t verdict_q [$];
	result_t want;

	int mismatches;
	int n_requests;
	int n_checked;
	int n_words_ok;
	int n_words_bad;
	int cycles;

	// Knobs shared between the stimulus process and the result consumer.
	bit tx_jitter;
	bit rx_jitter;
	bit rx_hold_req;

	// One row of the directed plan: either a register write or a request. A request may carry
	// a hand-written expected result; otherwise the shadow model supplies it.
	typedef struct {
		bit          is_reg;
		cfg_idx_t    idx;
		logic [63:0] val;
		action_t     act;
		logic [4:0]  row;
		logic [2:0]  col;
		logic [4:0]  tgt;
		logic [7:0]  sym;
		bit          typed;
		result_t     exp;
	} plan_row_t;

	plan_row_t plan [$];

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				verdict_q.size());
			$display("status: fail");
			$finish;
		end
	end

	// Effective alphabet width: the size register clamped to eight columns.
	function automatic int live_columns();
		return (sh_size > 4'd8) ? 8 : int'(sh_size);
	endfunction

	function automatic int live_states();
		return (sh_nstates > 6'd32) ? 32 : int'(sh_nstates);
	endfunction

	// Column of a symbol byte, lowest column first, or -1 when it is not in the alphabet.
	function automatic int column_of(logic [7:0] sym);
		for (int i = 0; i < live_columns(); i++) begin
			if (sh_chars[8*i +: 8] == sym)
				return i;
		end
		return -1;
	endfunction

	// Advances the shadow recognizer by one request and returns the result it must produce.
	function automatic result_t walk_predict(action_t act, logic [4:0] row, logic [2:0] col,
			logic [4:0] tgt, logic [7:0] sym);
		result_t r;
		int c;
		logic [4:0] nxt;
		r = '0;
		case (act)
			ACT_WRITE: begin
				sh_next[{row, col}] = tgt;
				sh_loaded[{row, col}] = 1'b1;
			end
			ACT_FEED: begin
				c = column_of(sym);
				if (c < 0) begin
					walk_bad = 1'b1;
				end else begin
					r.symbol_known = 1'b1;
					// A word that is already bad stays put; its symbols are only classified.
					if (!walk_bad) begin
						nxt = sh_next[{walk_state, 3'(c)}];
						if (int'(nxt) >= live_states())
							walk_bad = 1'b1;
						else
							walk_state = nxt;
					end
				end
			end
			ACT_END: begin
				r.word_done = 1'b1;
				r.bad_word = walk_bad;
				r.accepted = !walk_bad && sh_mask[walk_state];
				walk_state = '0;
				walk_bad = 1'b0;
			end
			default: begin
			end
		endcase
		r.current_state = walk_state;
		if (act != ACT_END)
			r.bad_word = walk_bad;
		return r;
	endfunction

	function automatic result_t res(int st, bit known, bit done, bit acc, bit bad);
		result_t r;
		r.current_state = 5'(st);
		r.symbol_known = known;
		r.word_done = done;
		r.accepted = acc;
		r.bad_word = bad;
		return r;
	endfunction

	function automatic void plan_reg(cfg_idx_t idx, logic [63:0] val);
		plan_row_t p;
		p = '{idx: CFG_ALPHA_CHARS, act: ACT_WRITE, default: '0};
		p.is_reg = 1'b1;
		p.idx = idx;
		p.val = val;
		plan.push_back(p);
	endfunction

	function automatic void plan_req(action_t act, int row, int col, int tgt, int sym,
			bit typed = 1'b0, result_t exp = '0);
		plan_row_t p;
		p = '{idx: CFG_ALPHA_CHARS, act: ACT_WRITE, default: '0};
		p.act = act;
		p.row = 5'(row);
		p.col = 3'(col);
		p.tgt = 5'(tgt);
		p.sym = 8'(sym);
		p.typed = typed;
		p.exp = exp;
		plan.push_back(p);
	endfunction

	// Offers one request, with an optional idle gap in front, and returns the predicted
	// result once the block has taken it. Valid stays high afterwards so that back-to-back
	// requests need no second assignment in the same step.
	task automatic offer(action_t act, logic [4:0] row, logic [2:0] col, logic [4:0] tgt,
			logic [7:0] sym, output result_t predicted);
		int gap;
		gap = (tx_jitter && $urandom_range(99) < 23) ? $urandom_range(1, 4) : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {3'b000, sym, tgt, col, row};
		do @(posedge clk); while (!s_tready);
		n_requests++;
		predicted = walk_predict(act, row, col, tgt, sym);
	endtask

	// Stops offering and waits until every outstanding result has come back. Since each
	// request gives exactly one result, an empty queue means the block is idle.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
	endtask

	// Writes one register. The caller lowers cfg_valid after the last write of a batch.
	task automatic write_reg(cfg_idx_t idx, logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_ALPHA_CHARS: sh_chars = val;
			CFG_ALPHA_SIZE:  sh_size = val[3:0];
			CFG_NUM_STATES:  sh_nstates = val[5:0];
			CFG_FINAL_MASK:  sh_mask = val[31:0];
			default: begin
			end
		endcase
	endtask

	// Result consumer. It runs freely, drops ready at random, and on request holds off for a
	// long stretch so that the internal queue fills and the request side backs up.
	initial begin
		int hold;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				m_tready <= 1'b0;
				for (hold = 0; hold < RX_HOLD_CYCLES; hold++) @(posedge clk);
			end else begin
				m_tready <= !(rx_jitter && $urandom_range(99) < 23);
			end
		end
	end

	// Checker: every accepted result is matched against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (verdict_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result st=%0d known=%0b done=%0b acc=%0b bad=%0b",
						m_tdata[4:0], m_tdata[5], m_tuser, m_tdata[6], m_tdata[7]);
			end else begin
				want = verdict_q.pop_front();
				n_checked++;
				if (want.word_done && want.accepted)
					n_words_ok++;
				else if (want.word_done)
					n_words_bad++;
				if (m_tdata[4:0] !== want.current_state || m_tdata[5] !== want.symbol_known ||
						m_tuser !== want.word_done || m_tdata[6] !== want.accepted ||
						m_tdata[7] !== want.bad_word) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch on result %0d: want st=%0d known=%0b done=%0b ",
							"acc=%0b bad=%0b, got st=%0d known=%0b done=%0b acc=%0b bad=%0b"},
							n_checked, want.current_state, want.symbol_known, want.word_done,
							want.accepted, want.bad_word, m_tdata[4:0], m_tdata[5], m_tuser,
							m_tdata[6], m_tdata[7]);
				end
			end
		end
	end

	initial begin
		result_t got;
		int sent;
		int roll;
		int c;
		int live;
		int ncols;
		int asz;
		int nst;
		bit held;
		logic [63:0] chars;
		logic [7:0] sym;
		logic [4:0] tgt;

		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_ALPHA_CHARS;
		cfg_data <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= ACT_NONE;
		tx_jitter = 1'b1;
		rx_jitter = 1'b1;
		rx_hold_req = 1'b0;
		held = 1'b0;

		// Shadow state after reset: empty alphabet, one state, no final states.
		sh_chars = '0;
		sh_size = '0;
		sh_nstates = 6'd1;
		sh_mask = '0;
		walk_state = '0;
		walk_bad = 1'b0;
		foreach (sh_loaded[i]) begin
			sh_loaded[i] = 1'b0;
			sh_next[i] = '0;
		end

		// Directed plan. With the reset alphabet every symbol is unknown, so a word that feeds a symbol
		// goes bad at once, and the unused action leaves everything as it was.
		plan_req(ACT_END, 0, 0, 0, 0, 1'b1, res(0, 0, 1, 0, 0));
		plan_req(ACT_NONE, 31, 7, 31, 255, 1'b1, res(0, 0, 0, 0, 0));
		plan_req(ACT_FEED, 0, 0, 0, 8'h00, 1'b1, res(0, 0, 0, 0, 1));
		plan_req(ACT_FEED, 31, 7, 31, 8'hFF, 1'b1, res(0, 0, 0, 0, 1));
		plan_req(ACT_END, 0, 0, 0, 0, 1'b1, res(0, 0, 1, 0, 1));
		plan_req(ACT_WRITE, 31, 7, 31, 0, 1'b1, res(0, 0, 0, 0, 0));
		plan_req(ACT_WRITE, 0, 0, 0, 255, 1'b1, res(0, 0, 0, 0, 0));
		// Alphabet with a repeated byte in columns 0 and 3, plus the byte extremes. The size and
		// state count are written with bits above their widths, and the count exceeds 32.
		plan_reg(CFG_ALPHA_CHARS, 64'h0706_0504_61FF_0061);
		plan_reg(CFG_ALPHA_SIZE, 64'hFFFF_FFFF_FFFF_FFF8);
		plan_reg(CFG_NUM_STATES, 64'h0000_0000_0000_00FF);
		plan_reg(CFG_FINAL_MASK, 64'hFFFF_FFFF_8000_0001);
		plan_req(ACT_WRITE, 0, 2, 31, 0);
		plan_req(ACT_WRITE, 31, 0, 0, 0);
		plan_req(ACT_FEED, 0, 0, 0, 8'hFF);
		plan_req(ACT_END, 0, 0, 0, 0);
		plan_req(ACT_FEED, 0, 0, 0, 8'h61);
		plan_req(ACT_END, 0, 0, 0, 0);
		// A state count of zero turns every move into a bad state; a bad word then only
		// classifies its symbols.
		plan_reg(CFG_NUM_STATES, 64'd0);
		plan_req(ACT_FEED, 0, 0, 0, 8'h61, 1'b1, res(0, 1, 0, 0, 1));
		plan_req(ACT_FEED, 0, 0, 0, 8'h07, 1'b1, res(0, 1, 0, 0, 1));
		plan_req(ACT_END, 0, 0, 0, 0, 1'b1, res(0, 0, 1, 0, 1));
		// An unknown symbol in the middle of a word holds the state and spoils the word.
		plan_reg(CFG_NUM_STATES, 64'd63);
		plan_req(ACT_FEED, 0, 0, 0, 8'hFF);
		plan_req(ACT_FEED, 0, 0, 0, 8'h42);
		plan_req(ACT_FEED, 0, 0, 0, 8'h61);
		plan_req(ACT_END, 0, 0, 0, 0, 1'b1, res(0, 0, 1, 0, 1));
		// A table entry that points past the state count marks the word bad.
		plan_reg(CFG_NUM_STATES, 64'd5);
		plan_req(ACT_FEED, 0, 0, 0, 8'hFF);
		plan_req(ACT_END, 0, 0, 0, 0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < plan.size(); i++) begin
			if (plan[i].is_reg) begin
				if (i == 0 || !plan[i-1].is_reg)
					settle();
				write_reg(plan[i].idx, plan[i].val);
				if (i + 1 == plan.size() || !plan[i+1].is_reg)
					cfg_valid <= 1'b0;
			end else begin
				offer(plan[i].act, plan[i].row, plan[i].col, plan[i].tgt, plan[i].sym, got);
				verdict_q.push_back(plan[i].typed ? plan[i].exp : got);
			end
		end

		// Random phases. Each starts from an idle block with a fresh register setting. Most
		// requests are symbols from the alphabet so that words really walk the table; any entry
		// a symbol is about to read gets loaded first, since unloaded entries are undefined.
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			chars = {$urandom, $urandom};
			if ($urandom_range(3) == 0)
				chars[31:24] = chars[7:0];
			case (ph)
				0: begin asz = 8; nst = 63; end
				1: begin asz = 1; nst = 1; end
				2: begin asz = 15; nst = 32; end
				default: begin
					asz = ($urandom_range(4) == 0) ? $urandom_range(15) : $urandom_range(1, 8);
					nst = ($urandom_range(5) == 0) ? $urandom_range(63) : $urandom_range(1, 8);
				end
			endcase
			settle();
			write_reg(CFG_ALPHA_CHARS, chars);
			write_reg(CFG_ALPHA_SIZE, 64'(asz));
			write_reg(CFG_NUM_STATES, 64'(nst));
			write_reg(CFG_FINAL_MASK, {$urandom, $urandom});
			cfg_valid <= 1'b0;

			// One phase runs with no idling on either side.
			tx_jitter = (ph != 3);
			rx_jitter = (ph != 3);

			sent = 0;
			while (sent < PHASE_ITEMS) begin
				// A symbol with its table load counts twice, so the count may step past 40.
				if (ph == 2 && sent >= 40 && !held) begin
					rx_hold_req = 1'b1;
					held = 1'b1;
				end
				live = live_states();
				ncols = live_columns();
				roll = $urandom_range(99);
				if (roll < 12) begin
					// Table load, half of them aimed at the part of the table in use.
					if ($urandom_range(1) == 0 && live > 0 && ncols > 0)
						offer(ACT_WRITE, 5'($urandom_range(live - 1)),
							3'($urandom_range(ncols - 1)), 5'($urandom_range(live - 1)),
							8'($urandom), got);
					else
						offer(ACT_WRITE, 5'($urandom), 3'($urandom), 5'($urandom),
							8'($urandom), got);
					verdict_q.push_back(got);
					sent++;
				end else if (roll < 80) begin
					if (ncols > 0 && $urandom_range(99) < 85)
						sym = sh_chars[8*$urandom_range(ncols - 1) +: 8];
					else
						sym = 8'($urandom);
					c = column_of(sym);
					if (c >= 0 && !walk_bad && !sh_loaded[{walk_state, 3'(c)}]) begin
						tgt = (live > 0 && $urandom_range(99) < 88) ?
							5'($urandom_range(live - 1)) : 5'($urandom);
						offer(ACT_WRITE, walk_state, 3'(c), tgt, 8'($urandom), got);
						verdict_q.push_back(got);
						sent++;
					end
					offer(ACT_FEED, 5'($urandom), 3'($urandom), 5'($urandom), sym, got);
					verdict_q.push_back(got);
					sent++;
				end else if (roll < 96) begin
					offer(ACT_END, 5'($urandom), 3'($urandom), 5'($urandom), 8'($urandom), got);
					verdict_q.push_back(got);
					sent++;
				end else begin
					offer(ACT_NONE, 5'($urandom), 3'($urandom), 5'($urandom), 8'($urandom),
						got);
					verdict_q.push_back(got);
					sent++;
				end
			end
		end

		settle();
		// Every request has been answered; the extra wait catches any stray extra result.
		repeat (6) @(posedge clk);

		$display("covered %0d requests in %0d register settings, %0d results checked",
			n_requests, RAND_PHASES + 4, n_checked);
		$display("words accepted %0d, words rejected %0d, mismatches %0d",
			n_words_ok, n_words_bad, mismatches);
		if (mismatches == 0 && verdict_q.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
